// ===== rtl/wsp_pkg.sv =====
// Package: codes, result type and helpers for the wheel session phase tracker.
package wsp_pkg;

    typedef enum logic [1:0] {
        ACT_UPDATE        = 2'd0,
        ACT_DISCARD_WHEEL = 2'd1,
        ACT_DISCARD_OTHER = 2'd2,
        ACT_ASSIGN        = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_SCROLL   = 2'd0,
        KIND_MOMENTUM = 2'd1,
        KIND_ZOOM     = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_NONE      = 3'd0,
        PH_MAY_BEGIN = 3'd1,
        PH_BEGAN     = 3'd2,
        PH_CHANGED   = 3'd3,
        PH_ENDED     = 3'd4,
        PH_CANCELLED = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_MAY   = 2'd1,
        ST_BEGUN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        DISP_UNCHANGED = 2'd0,
        DISP_ADAPTED   = 2'd1,
        DISP_REPLACED  = 2'd2,
        DISP_NA        = 2'd3
    } disp_t;

    localparam int unsigned QUEUE_DEPTH = 3;

    typedef struct packed {
        logic [1:0]  disposition;
        logic        event_valid;
        logic [1:0]  event_kind;
        logic [2:0]  event_phase;
        logic [31:0] event_amount;
        logic        session_ended;
        logic        last;
    } result_t;

    function automatic logic [1:0] ptr_inc(input logic [1:0] p);
        logic [1:0] r;
        begin
            r = (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
            return r;
        end
    endfunction

endpackage

// ===== rtl/wsp_step.sv =====
// Next-state and result logic for one beat of the session tracker.
module wsp_step
    import wsp_pkg::*;
(
    input  logic [1:0]  action,
    input  logic [1:0]  wheel_kind,
    input  logic [2:0]  phase_in,
    input  logic [31:0] zoom_amount,
    input  logic [1:0]  status,
    input  logic [1:0]  kind,
    output logic [1:0]  status_next,
    output logic [1:0]  kind_next,
    output logic        two,
    output result_t     res0,
    output result_t     res1
);

    logic [1:0] k;
    logic [2:0] p;
    logic [2:0] ph;
    logic       emit;
    logic       ended;
    result_t    disc_wheel;
    result_t    disc_other;
    result_t    drop;
    result_t    r0;
    result_t    r1;

    always_comb
    begin
        k = (wheel_kind == 2'd3) ? KIND_ZOOM : wheel_kind;
        p = (phase_in > PH_CANCELLED) ? PH_NONE : phase_in;

        drop = '0;
        drop.disposition = DISP_REPLACED;

        disc_wheel = '0;
        disc_other = '0;
        disc_other.disposition = DISP_NA;
        if (status != ST_FREE)
        begin
            disc_wheel.event_valid = 1'b1;
            disc_wheel.event_kind  = (kind == KIND_ZOOM) ? KIND_ZOOM : kind;
            disc_wheel.event_phase = (status == ST_MAY) ? PH_CANCELLED : PH_ENDED;
            disc_wheel.disposition = (kind == KIND_ZOOM) ? DISP_REPLACED : DISP_ADAPTED;
            disc_other.event_valid = 1'b1;
            disc_other.event_kind  = disc_wheel.event_kind;
            disc_other.event_phase = disc_wheel.event_phase;
        end

        status_next = status;
        kind_next   = kind;
        two         = 1'b0;
        r0          = '0;
        r1          = '0;
        ph          = p;
        emit        = 1'b0;

        case (action)
            ACT_UPDATE:
            begin
                if (k != KIND_SCROLL && p == PH_MAY_BEGIN)
                begin
                    r0 = drop;
                end
                else if ((p == PH_NONE && k == KIND_SCROLL) ||
                         (status != ST_FREE && kind != k))
                begin
                    r0 = disc_wheel;
                    status_next = ST_FREE;
                end
                else
                begin
                    emit = 1'b1;
                    case (status)
                        ST_FREE:
                        begin
                            if (p == PH_MAY_BEGIN)
                                status_next = ST_MAY;
                            else if (p == PH_ENDED || p == PH_CANCELLED)
                            begin
                                emit = 1'b0;
                                r0 = drop;
                            end
                            else
                            begin
                                status_next = ST_BEGUN;
                                ph = PH_BEGAN;
                            end
                        end
                        ST_MAY:
                        begin
                            if (p == PH_MAY_BEGIN)
                            begin
                                emit = 1'b0;
                                r0 = drop;
                            end
                            else if (p == PH_ENDED)
                            begin
                                status_next = ST_FREE;
                                ph = PH_CANCELLED;
                            end
                            else if (p == PH_CANCELLED)
                                status_next = ST_FREE;
                            else
                            begin
                                status_next = ST_BEGUN;
                                ph = PH_BEGAN;
                            end
                        end
                        default:
                        begin
                            if (p == PH_MAY_BEGIN)
                            begin
                                emit = 1'b0;
                                r0 = drop;
                            end
                            else if (p == PH_ENDED || p == PH_CANCELLED)
                                status_next = ST_FREE;
                            else
                                ph = PH_CHANGED;
                        end
                    endcase

                    if (emit)
                    begin
                        kind_next = k;
                        if (k == KIND_ZOOM)
                        begin
                            r0.disposition = DISP_REPLACED;
                            r0.event_valid = 1'b1;
                            r0.event_kind  = KIND_ZOOM;
                            if (ph == PH_BEGAN && zoom_amount != 32'd0)
                            begin
                                two = 1'b1;
                                r0.event_phase = PH_BEGAN;
                                r1.disposition  = DISP_REPLACED;
                                r1.event_valid  = 1'b1;
                                r1.event_kind   = KIND_ZOOM;
                                r1.event_phase  = PH_CHANGED;
                                r1.event_amount = zoom_amount;
                            end
                            else
                            begin
                                r0.event_phase  = ph;
                                r0.event_amount = zoom_amount;
                            end
                        end
                        else if (ph != p)
                        begin
                            r0.disposition = DISP_ADAPTED;
                            r0.event_valid = 1'b1;
                            r0.event_kind  = k;
                            r0.event_phase = ph;
                        end
                    end
                end
            end
            ACT_DISCARD_WHEEL:
            begin
                r0 = disc_wheel;
                status_next = ST_FREE;
            end
            ACT_DISCARD_OTHER:
            begin
                r0 = disc_other;
                status_next = ST_FREE;
            end
            default:
            begin
                kind_next = k;
                r0.disposition = DISP_NA;
                if (p == PH_MAY_BEGIN)
                    status_next = ST_MAY;
                else if (p == PH_BEGAN || p == PH_CHANGED)
                    status_next = ST_BEGUN;
                else
                    status_next = ST_FREE;
            end
        endcase

        ended = (status_next == ST_FREE) &&
                (p == PH_ENDED || p == PH_CANCELLED || p == PH_NONE);
        r0.session_ended = ended;
        r1.session_ended = ended;
        r0.last = ~two;
        r1.last = 1'b1;

        res0 = r0;
        res1 = r1;
    end

endmodule

// ===== rtl/wheel_session_phase_tracker.sv =====
// Top level: wheel session phase tracker with a three-entry result queue.
// Each result is written into the result queue as its input beat is accepted.
// Throughput, while out_ready is high: one input beat per cycle while each
// yields one result; two results (zoom began, nonzero amount) drain one
// per cycle. in_ready is high while the result queue holds at most one entry.
// Reset (rst_n low, asynchronous): session free, kind scroll, queue empty.
module wheel_session_phase_tracker
    import wsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [1:0]  wheel_kind,
    input  logic [2:0]  phase_in,
    input  logic [31:0] zoom_amount,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  disposition,
    output logic        event_valid,
    output logic [1:0]  event_kind,
    output logic [2:0]  event_phase,
    output logic [31:0] event_amount,
    output logic        session_ended,
    output logic        last
);

    logic [1:0] status_reg;
    logic [1:0] kind_reg;
    logic [1:0] status_next;
    logic [1:0] kind_next;
    logic       two;
    result_t    res0;
    result_t    res1;

    result_t    queue_reg [QUEUE_DEPTH];
    logic [1:0] wr_reg;
    logic [1:0] rd_reg;
    logic [1:0] count_reg;
    logic [1:0] wr_next;
    logic [1:0] rd_next;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    result_t    head;

    wsp_step u_step (
        .action      (action),
        .wheel_kind  (wheel_kind),
        .phase_in    (phase_in),
        .zoom_amount (zoom_amount),
        .status      (status_reg),
        .kind        (kind_reg),
        .status_next (status_next),
        .kind_next   (kind_next),
        .two         (two),
        .res0        (res0),
        .res1        (res1)
    );

    assign in_ready  = (count_reg <= 2'd1);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
            wr_next = two ? ptr_inc(ptr_inc(wr_reg)) : ptr_inc(wr_reg);
        if (pop)
            rd_next = ptr_inc(rd_reg);
        count_next = count_reg + (push ? (two ? 2'd2 : 2'd1) : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_FREE;
            kind_reg   <= KIND_SCROLL;
            wr_reg     <= 2'd0;
            rd_reg     <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                status_reg <= status_next;
                kind_reg   <= kind_next;
            end
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_reg] <= res0;
            if (two)
                queue_reg[ptr_inc(wr_reg)] <= res1;
        end
    end

    assign head          = queue_reg[rd_reg];
    assign disposition   = head.disposition;
    assign event_valid   = head.event_valid;
    assign event_kind    = head.event_kind;
    assign event_phase   = head.event_phase;
    assign event_amount  = head.event_amount;
    assign session_ended = head.session_ended;
    assign last          = head.last;

endmodule

// ===== tb/wsp_session_checker.sv =====
// Checker: predicts wheel session tracker results from accepted input beats and compares them.
module wsp_session_checker
    import wsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  action,
    input  logic [1:0]  wheel_kind,
    input  logic [2:0]  phase_in,
    input  logic [31:0] zoom_amount,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  disposition,
    input  logic        event_valid,
    input  logic [1:0]  event_kind,
    input  logic [2:0]  event_phase,
    input  logic [31:0] event_amount,
    input  logic        session_ended,
    input  logic        last,
    output int          error_count,
    output int          pending_count
);

    localparam int REPORT_LIMIT = 10;

    status_t sess_status;
    kind_t   sess_kind;
    result_t expected_results[$];
    result_t want;
    result_t got;
    int      errors;

    function automatic result_t pack_result(input disp_t disp, input logic valid,
                                            input kind_t kind, input phase_t ph,
                                            input logic [31:0] amount);
        result_t r;
        r.disposition   = disp;
        r.event_valid   = valid;
        r.event_kind    = valid ? kind : KIND_SCROLL;
        r.event_phase   = valid ? ph : PH_NONE;
        r.event_amount  = valid ? amount : '0;
        r.session_ended = 1'b0;
        r.last          = 1'b0;
        return r;
    endfunction

    // closes an open session; kind is kept
    function automatic result_t close_session(input logic by_wheel);
        phase_t  ph;
        result_t r;
        if (sess_status == ST_FREE)
        begin
            r = pack_result(by_wheel ? DISP_UNCHANGED : DISP_NA, 1'b0, KIND_SCROLL,
                            PH_NONE, '0);
        end
        else
        begin
            ph = (sess_status == ST_MAY) ? PH_CANCELLED : PH_ENDED;
            sess_status = ST_FREE;
            if (sess_kind == KIND_ZOOM)
                r = pack_result(by_wheel ? DISP_REPLACED : DISP_NA, 1'b1, KIND_ZOOM, ph, '0);
            else
                r = pack_result(by_wheel ? DISP_ADAPTED : DISP_NA, 1'b1, sess_kind, ph, '0);
        end
        return r;
    endfunction

    task automatic predict_session_step(input logic [1:0] act_raw, input logic [1:0] kind_raw,
                                        input logic [2:0] ph_raw, input logic [31:0] amt);
        kind_t   kind;
        phase_t  phase;
        phase_t  ph;
        result_t res [2];
        int      n;
        int      k;
        logic    drop;
        logic    ended;
        kind  = (kind_raw > KIND_ZOOM) ? KIND_ZOOM : kind_t'(kind_raw);
        phase = (ph_raw > PH_CANCELLED) ? PH_NONE : phase_t'(ph_raw);
        ph    = phase;
        n     = 1;
        drop  = 1'b0;
        res[1] = '0;
        case (action_t'(act_raw))
            ACT_UPDATE:
            begin
                if (kind != KIND_SCROLL && phase == PH_MAY_BEGIN)
                    res[0] = pack_result(DISP_REPLACED, 1'b0, KIND_SCROLL, PH_NONE, '0);
                else if (phase == PH_NONE && kind == KIND_SCROLL)
                    res[0] = close_session(1'b1);
                else if (sess_status != ST_FREE && sess_kind != kind)
                    res[0] = close_session(1'b1);
                else
                begin
                    case (sess_status)
                        ST_FREE:
                        begin
                            if (phase == PH_MAY_BEGIN)
                                sess_status = ST_MAY;
                            else if (phase == PH_ENDED || phase == PH_CANCELLED)
                                drop = 1'b1;
                            else
                            begin
                                sess_status = ST_BEGUN;
                                ph = PH_BEGAN;
                            end
                        end
                        ST_MAY:
                        begin
                            if (phase == PH_MAY_BEGIN)
                                drop = 1'b1;
                            else if (phase == PH_ENDED)
                            begin
                                sess_status = ST_FREE;
                                ph = PH_CANCELLED;
                            end
                            else if (phase == PH_CANCELLED)
                                sess_status = ST_FREE;
                            else
                            begin
                                sess_status = ST_BEGUN;
                                ph = PH_BEGAN;
                            end
                        end
                        default:
                        begin
                            if (phase == PH_MAY_BEGIN)
                                drop = 1'b1;
                            else if (phase == PH_ENDED || phase == PH_CANCELLED)
                                sess_status = ST_FREE;
                            else
                                ph = PH_CHANGED;
                        end
                    endcase
                    if (drop)
                        res[0] = pack_result(DISP_REPLACED, 1'b0, KIND_SCROLL, PH_NONE, '0);
                    else
                    begin
                        sess_kind = kind;
                        if (kind == KIND_ZOOM)
                        begin
                            if (ph == PH_BEGAN && amt != '0)
                            begin
                                res[0] = pack_result(DISP_REPLACED, 1'b1, KIND_ZOOM,
                                                     PH_BEGAN, '0);
                                res[1] = pack_result(DISP_REPLACED, 1'b1, KIND_ZOOM,
                                                     PH_CHANGED, amt);
                                n = 2;
                            end
                            else
                                res[0] = pack_result(DISP_REPLACED, 1'b1, KIND_ZOOM, ph, amt);
                        end
                        else if (ph == phase)
                            res[0] = pack_result(DISP_UNCHANGED, 1'b0, KIND_SCROLL, PH_NONE, '0);
                        else
                            res[0] = pack_result(DISP_ADAPTED, 1'b1, kind, ph, '0);
                    end
                end
            end
            ACT_DISCARD_WHEEL:
                res[0] = close_session(1'b1);
            ACT_DISCARD_OTHER:
                res[0] = close_session(1'b0);
            default:
            begin
                sess_kind = kind;
                if (phase == PH_MAY_BEGIN)
                    sess_status = ST_MAY;
                else if (phase == PH_BEGAN || phase == PH_CHANGED)
                    sess_status = ST_BEGUN;
                else
                    sess_status = ST_FREE;
                res[0] = pack_result(DISP_NA, 1'b0, KIND_SCROLL, PH_NONE, '0);
            end
        endcase
        ended = (sess_status == ST_FREE) &&
                (phase == PH_ENDED || phase == PH_CANCELLED || phase == PH_NONE);
        for (k = 0; k < n; k++)
        begin
            res[k].session_ended = ended;
            res[k].last          = (k == n - 1);
            expected_results.push_back(res[k]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sess_status = ST_FREE;
            sess_kind   = KIND_SCROLL;
            expected_results.delete();
            errors = 0;
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{disposition, event_valid, event_kind, event_phase, event_amount,
                        session_ended, last};
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("mismatch: result beat with nothing expected, disp %0d phase %0d",
                                 disposition, event_phase);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.disposition !== want.disposition ||
                        got.event_valid !== want.event_valid ||
                        got.event_kind !== want.event_kind ||
                        got.event_phase !== want.event_phase ||
                        got.event_amount !== want.event_amount ||
                        got.session_ended !== want.session_ended ||
                        got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display({"mismatch (exp/act): disp %0d/%0d valid %0b/%0b ",
                                      "kind %0d/%0d phase %0d/%0d amount %08h/%08h ",
                                      "ended %0b/%0b last %0b/%0b"},
                                     want.disposition, got.disposition,
                                     want.event_valid, got.event_valid,
                                     want.event_kind, got.event_kind,
                                     want.event_phase, got.event_phase,
                                     want.event_amount, got.event_amount,
                                     want.session_ended, got.session_ended,
                                     want.last, got.last);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_session_step(action, wheel_kind, phase_in, zoom_amount);
            error_count   <= errors;
            pending_count <= expected_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives stimulus into the wheel session phase tracker and gives the verdict.
module tb_top;
    import wsp_pkg::*;

    localparam logic [1:0] KIND_CODE3     = 2'd3;
    localparam logic [2:0] PH_CODE6       = 3'd6;
    localparam logic [2:0] PH_CODE7       = 3'd7;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         PHASE_ITEMS    = 560;
    localparam int         DRAIN_CYCLES   = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [1:0]  wheel_kind;
    logic [2:0]  phase_in;
    logic [31:0] zoom_amount;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  disposition;
    logic        event_valid;
    logic [1:0]  event_kind;
    logic [2:0]  event_phase;
    logic [31:0] event_amount;
    logic        session_ended;
    logic        last;
    int          error_count;
    int          pending_count;

    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_req;
    logic        hold_done;
    int          hold_left;
    int          items_sent;
    int          stall_cycles;

    wheel_session_phase_tracker u_dut (.*);

    wsp_session_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [31:0] rand_amount();
        logic [31:0] a;
        case ($urandom_range(7))
            0: a = '0;
            1: a = 32'h7FFF_FFFF;
            2: a = 32'h8000_0000;
            3: a = 32'($signed($urandom_range(131072)) - 65536);
            default: a = $urandom;
        endcase
        return a;
    endfunction

    task automatic send_beat(input logic [1:0] act, input logic [1:0] kind,
                             input logic [2:0] ph, input logic [31:0] amt);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        wheel_kind  <= kind;
        phase_in    <= ph;
        zoom_amount <= amt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_gesture();
        logic [1:0] kind;
        int         n_chg;
        kind  = 2'($urandom_range(3));
        n_chg = $urandom_range(6);
        if ($urandom_range(3) == 0)
            send_beat(ACT_UPDATE, kind, PH_MAY_BEGIN, rand_amount());
        send_beat(ACT_UPDATE, kind, PH_BEGAN, rand_amount());
        repeat (n_chg)
            send_beat(ACT_UPDATE, kind, PH_CHANGED, rand_amount());
        case ($urandom_range(7))
            0: send_beat(ACT_DISCARD_WHEEL, kind, PH_NONE, '0);
            1: send_beat(ACT_DISCARD_OTHER, kind, PH_NONE, '0);
            2: send_beat(ACT_UPDATE, 2'($urandom_range(3)), PH_CHANGED, rand_amount());
            3: send_beat(ACT_UPDATE, kind, PH_CANCELLED, rand_amount());
            default: send_beat(ACT_UPDATE, kind, PH_ENDED, rand_amount());
        endcase
    endtask

    task automatic run_random(input int target);
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 75)
                send_gesture();
            else
                send_beat(2'($urandom_range(3)), 2'($urandom_range(3)),
                          3'($urandom_range(7)), rand_amount());
        end
    endtask

    // receiver: random backpressure plus one long hold-off
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = ACT_UPDATE;
        wheel_kind  = KIND_SCROLL;
        phase_in    = PH_NONE;
        zoom_amount = '0;
        hold_req    = 1'b0;
        items_sent  = 0;
        tx_idle_pct = 11;
        rx_idle_pct = 75;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_NONE, '0);
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_MAY_BEGIN, '0);
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_MAY_BEGIN, '0);
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_BEGAN, '0);
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_CHANGED, 32'hFFFF_FFFF);
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_MAY_BEGIN, '0);
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_ENDED, '0);
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_ENDED, '0);
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_MAY_BEGIN, '0);
        send_beat(ACT_UPDATE, KIND_SCROLL, PH_ENDED, '0);
        send_beat(ACT_UPDATE, KIND_ZOOM, PH_MAY_BEGIN, 32'h0001_0000);
        send_beat(ACT_UPDATE, KIND_ZOOM, PH_CHANGED, 32'h7FFF_FFFF);
        send_beat(ACT_UPDATE, KIND_ZOOM, PH_CHANGED, 32'h8000_0000);
        send_beat(ACT_UPDATE, KIND_MOMENTUM, PH_CHANGED, '0);
        send_beat(ACT_UPDATE, KIND_CODE3, PH_BEGAN, '0);
        send_beat(ACT_UPDATE, KIND_ZOOM, PH_CODE6, 32'hFFFF_FFFF);
        send_beat(ACT_DISCARD_WHEEL, KIND_SCROLL, PH_NONE, '0);
        send_beat(ACT_DISCARD_WHEEL, KIND_SCROLL, PH_NONE, '0);
        send_beat(ACT_DISCARD_OTHER, KIND_SCROLL, PH_NONE, '0);
        send_beat(ACT_ASSIGN, KIND_MOMENTUM, PH_BEGAN, '0);
        send_beat(ACT_UPDATE, KIND_MOMENTUM, PH_CANCELLED, '0);
        send_beat(ACT_ASSIGN, KIND_SCROLL, PH_MAY_BEGIN, '0);
        send_beat(ACT_DISCARD_OTHER, KIND_SCROLL, PH_NONE, '0);
        send_beat(ACT_ASSIGN, KIND_CODE3, PH_CODE7, 32'hFFFF_FFFF);
        send_beat(ACT_UPDATE, KIND_MOMENTUM, PH_NONE, 32'h0000_8000);

        run_random(items_sent + PHASE_ITEMS);

        tx_idle_pct = 75;
        rx_idle_pct = 11;
        run_random(items_sent + PHASE_ITEMS);

        // no idling; receiver holds off so the result queue fills
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        run_random(items_sent + PHASE_ITEMS);

        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
